>>> rtl/ks_pkg.sv
// ks_pkg: shared types, constants and control structs for the knapsack select unit.
// No dependencies.
package ks_pkg;

    localparam int MAX_ITEMS_DEF    = 32;
    localparam int MAX_CAPACITY_DEF = 255;
    localparam int VAL_W            = 21;
    localparam int WT_W             = 8;
    localparam int IV_W             = 16;
    localparam int IDX_W            = 5;
    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    typedef enum logic [1:0] {
        REG_CAPACITY = 2'd0
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RD,
        ST_UPD,
        ST_WALK_RD,
        ST_WALK,
        ST_EMIT_RD,
        ST_EMIT,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic start_set;    // latch capacity, reset counters
        logic take_item;    // capture item fields at the input transfer
        logic clr_wr;       // clear best row at cap_cnt
        logic load_item;    // cap_cnt <= set_cap
        logic upd_rd;       // issue row reads for cap_cnt
        logic upd_wr;       // write back cell, step cap_cnt down
        logic upd_end;      // store item, count it as loaded
        logic walk_init;    // n <= items_loaded, w <= set_cap
        logic walk_rd;      // read take bit / weight
        logic walk_step;    // apply walk decision
        logic emit_init;    // pick first selection
        logic emit_rd;      // read item stores
        logic emit_fire;    // present result
        logic emit_step;    // advance to next selection
    } ks_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic cnt_zero;     // cap_cnt == 0
        logic room;         // items_loaded < MAX_ITEMS
        logic walk_done;    // n == 0 or w == 0
        logic sel_none;     // no selected items left to emit
    } ks_sts_t;

endpackage

>>> rtl/ks_ram.sv
// ks_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/ks_ctrl.sv
// ks_ctrl: sequencer for clear, row update, backtrack walk and result emission.
// Depends on ks_pkg.
module ks_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            last_item,
    input  ks_pkg::ks_sts_t sts,
    output ks_pkg::ks_cmd_t cmd,
    output logic            busy
);
    ks_pkg::state_t state_reg, state_next;
    logic in_set_reg, in_set_next;
    logic last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ks_pkg::ST_IDLE;
            in_set_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            in_set_reg <= in_set_next;
            last_reg   <= last_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_set_next = in_set_reg;
        last_next   = last_reg;
        cmd         = '0;
        busy        = 1'b1;
        case (state_reg)
            ks_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    last_next = last_item;
                    if (!in_set_reg)
                    begin
                        cmd.start_set = 1'b1;
                        cmd.take_item = 1'b1;
                        in_set_next   = 1'b1;
                        state_next    = ks_pkg::ST_CLEAR;
                    end
                    else if (sts.room)
                    begin
                        cmd.load_item = 1'b1;
                        cmd.take_item = 1'b1;
                        state_next    = ks_pkg::ST_RD;
                    end
                    else if (last_item)
                    begin
                        cmd.walk_init = 1'b1;
                        state_next    = ks_pkg::ST_WALK_RD;
                    end
                end
            end
            ks_pkg::ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.cnt_zero)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ks_pkg::ST_RD;
                end
            end
            ks_pkg::ST_RD:
            begin
                cmd.upd_rd = 1'b1;
                state_next = ks_pkg::ST_UPD;
            end
            ks_pkg::ST_UPD:
            begin
                cmd.upd_wr = 1'b1;
                if (sts.cnt_zero)
                begin
                    cmd.upd_end = 1'b1;
                    if (last_reg)
                    begin
                        state_next = ks_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = ks_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ks_pkg::ST_RD;
                end
            end
            ks_pkg::ST_DONE:
            begin
                cmd.walk_init = 1'b1;
                state_next    = ks_pkg::ST_WALK_RD;
            end
            ks_pkg::ST_WALK_RD:
            begin
                if (sts.walk_done)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = ks_pkg::ST_EMIT_RD;
                end
                else
                begin
                    cmd.walk_rd = 1'b1;
                    state_next  = ks_pkg::ST_WALK;
                end
            end
            ks_pkg::ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                state_next    = ks_pkg::ST_WALK_RD;
            end
            ks_pkg::ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = ks_pkg::ST_EMIT;
            end
            ks_pkg::ST_EMIT:
            begin
                cmd.emit_fire = 1'b1;
                cmd.emit_step = 1'b1;
                if (sts.sel_none)
                begin
                    in_set_next = 1'b0;
                    state_next  = ks_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = ks_pkg::ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ks_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

>>> rtl/ks_dp.sv
// ks_dp: best-value row, take-bit store, item stores, walk and selection registers.
// Depends on ks_pkg and ks_ram.
module ks_dp #(
    parameter int MAX_ITEMS    = ks_pkg::MAX_ITEMS_DEF,
    parameter int MAX_CAPACITY = ks_pkg::MAX_CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ks_pkg::ks_cmd_t             cmd,
    output ks_pkg::ks_sts_t             sts,
    input  logic [ks_pkg::WT_W-1:0]     capacity,
    input  logic [ks_pkg::WT_W-1:0]     item_weight,
    input  logic [ks_pkg::IV_W-1:0]     item_value,
    output logic                        result_valid,
    output logic [ks_pkg::VAL_W-1:0]    total_value,
    output logic                        has_item,
    output logic [ks_pkg::IDX_W-1:0]    item_index,
    output logic [ks_pkg::WT_W-1:0]     sel_weight,
    output logic [ks_pkg::IV_W-1:0]     sel_value,
    output logic                        last_result
);
    localparam int CW    = $clog2(MAX_CAPACITY + 1);
    localparam int IW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int NW    = $clog2(MAX_ITEMS + 1);
    localparam int TDEP  = MAX_ITEMS * (MAX_CAPACITY + 1);
    localparam int TW    = $clog2(TDEP);
    localparam int VW    = ks_pkg::VAL_W;
    localparam logic [CW-1:0] CAP_MAX = CW'(MAX_CAPACITY);

    logic [CW-1:0]           set_cap_reg, set_cap_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [NW-1:0]           loaded_reg, loaded_next;
    logic [ks_pkg::WT_W-1:0] wt_reg;
    logic [ks_pkg::IV_W-1:0] val_reg;
    logic [NW-1:0]           walk_n_reg, walk_n_next;
    logic [CW-1:0]           walk_w_reg, walk_w_next;
    logic [MAX_ITEMS-1:0]    sel_reg, sel_next;
    logic                    any_reg, any_next;
    logic [IW-1:0]           cur_reg, cur_next;
    logic [VW-1:0]           total_reg;
    logic                    total_ld_reg;

    // best row: two read ports via two RAM copies (excl at w, incl at w-wt)
    logic          row_we;
    logic [CW-1:0] row_waddr;
    logic [VW-1:0] row_wdata, excl_q, base_q;
    logic [CW-1:0] base_addr;
    logic          incl_ok_reg;

    logic          tk_we, tk_q;
    logic [TW-1:0] tk_waddr, tk_raddr;
    logic [IW-1:0] wraddr_item, rd_item;
    logic [ks_pkg::WT_W-1:0] sw_q;
    logic [ks_pkg::IV_W-1:0] sv_q;
    logic [IW-1:0] walk_item;

    logic [VW:0]   incl_sum;
    logic [VW-1:0] incl_v;
    logic          take;

    logic          cap_big;
    logic [IW-1:0] first_sel, next_sel;
    logic          next_any;

    // clamp test on the full register value
    assign cap_big    = (32'(capacity) > 32'(MAX_CAPACITY));
    assign walk_item  = IW'(walk_n_reg - NW'(1));
    assign wraddr_item = IW'(loaded_reg);
    assign base_addr  = cnt_reg - CW'(wt_reg);

    // item weight is 8 bits; CW may be narrower or wider
    always_comb
    begin
        incl_sum = {1'b0, base_q} + (VW+1)'(val_reg);
        incl_v   = incl_sum[VW] ? ks_pkg::VAL_MAX : incl_sum[VW-1:0];
        if (!incl_ok_reg)
        begin
            incl_v = '0;
        end
        take = incl_v > excl_q;
    end

    always_comb
    begin
        row_we    = cmd.clr_wr | cmd.upd_wr;
        row_waddr = cnt_reg;
        row_wdata = cmd.clr_wr ? '0 : (take ? incl_v : excl_q);
    end

    assign tk_we    = cmd.upd_wr;
    assign tk_waddr = TW'(wraddr_item * (MAX_CAPACITY + 1) + cnt_reg);
    assign tk_raddr = TW'(walk_item * (MAX_CAPACITY + 1) + walk_w_reg);
    assign rd_item  = cmd.walk_rd ? walk_item : cur_reg;

    ks_ram #(.WIDTH(VW), .DEPTH(MAX_CAPACITY + 1)) u_row_a (
        .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
        .raddr(cnt_reg), .rdata(excl_q)
    );
    ks_ram #(.WIDTH(VW), .DEPTH(MAX_CAPACITY + 1)) u_row_b (
        .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
        .raddr(cmd.walk_init ? set_cap_reg : base_addr), .rdata(base_q)
    );
    ks_ram #(.WIDTH(1), .DEPTH(TDEP)) u_take (
        .clk(clk), .we(tk_we), .waddr(tk_waddr), .wdata(take),
        .raddr(tk_raddr), .rdata(tk_q)
    );
    // item stores written once the row pass of that item ends
    ks_ram #(.WIDTH(ks_pkg::WT_W), .DEPTH(MAX_ITEMS)) u_wt (
        .clk(clk), .we(cmd.upd_end), .waddr(wraddr_item), .wdata(wt_reg),
        .raddr(rd_item), .rdata(sw_q)
    );
    ks_ram #(.WIDTH(ks_pkg::IV_W), .DEPTH(MAX_ITEMS)) u_val (
        .clk(clk), .we(cmd.upd_end), .waddr(wraddr_item), .wdata(val_reg),
        .raddr(rd_item), .rdata(sv_q)
    );

    // lowest / next selected index search over the selection mask
    always_comb
    begin
        first_sel = '0;
        for (int k = MAX_ITEMS - 1; k >= 0; k--)
        begin
            if (sel_reg[k])
            begin
                first_sel = IW'(k);
            end
        end
        next_sel = '0;
        next_any = 1'b0;
        for (int k = MAX_ITEMS - 1; k >= 0; k--)
        begin
            if (sel_reg[k] && (IW'(k) > cur_reg))
            begin
                next_sel = IW'(k);
                next_any = 1'b1;
            end
        end
    end

    always_comb
    begin
        set_cap_next = set_cap_reg;
        cnt_next     = cnt_reg;
        loaded_next  = loaded_reg;
        walk_n_next  = walk_n_reg;
        walk_w_next  = walk_w_reg;
        sel_next     = sel_reg;
        any_next     = any_reg;
        cur_next     = cur_reg;
        if (cmd.start_set)
        begin
            set_cap_next = cap_big ? CAP_MAX : CW'(capacity);
            cnt_next     = CAP_MAX;
            loaded_next  = '0;
        end
        if (cmd.clr_wr && cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
        if (cmd.load_item)
        begin
            cnt_next = set_cap_reg;
        end
        if (cmd.upd_wr && cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
        if (cmd.upd_end)
        begin
            loaded_next = loaded_reg + NW'(1);
        end
        if (cmd.walk_init)
        begin
            walk_n_next = loaded_reg;
            walk_w_next = set_cap_reg;
            sel_next    = '0;
        end
        if (cmd.walk_step)
        begin
            if (tk_q)
            begin
                sel_next[walk_item] = 1'b1;
                walk_w_next         = walk_w_reg - CW'(sw_q);
            end
            walk_n_next = walk_n_reg - NW'(1);
        end
        if (cmd.emit_init)
        begin
            cur_next = first_sel;
            any_next = |sel_reg;
        end
        if (cmd.emit_step)
        begin
            cur_next = next_sel;
            any_next = next_any;
            if (!any_reg)
            begin
                loaded_next = '0;
            end
        end
    end

    // include is possible when w >= weight; computed with the read
    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            wt_reg  <= item_weight;
            val_reg <= item_value;
        end
        if (cmd.upd_rd)
        begin
            incl_ok_reg <= ({1'b0, cnt_reg} >= (CW+1)'(wt_reg)) &&
                           ((CW >= ks_pkg::WT_W) || (wt_reg <= ks_pkg::WT_W'(MAX_CAPACITY)));
        end
        // row cell at set_cap arrives the cycle after walk_init
        if (total_ld_reg)
        begin
            total_reg <= base_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_cap_reg  <= '0;
            cnt_reg      <= '0;
            loaded_reg   <= '0;
            walk_n_reg   <= '0;
            walk_w_reg   <= '0;
            sel_reg      <= '0;
            any_reg      <= 1'b0;
            cur_reg      <= '0;
            total_ld_reg <= 1'b0;
        end
        else
        begin
            set_cap_reg  <= set_cap_next;
            cnt_reg      <= cnt_next;
            loaded_reg   <= loaded_next;
            walk_n_reg   <= walk_n_next;
            walk_w_reg   <= walk_w_next;
            sel_reg      <= sel_next;
            any_reg      <= any_next;
            cur_reg      <= cur_next;
            total_ld_reg <= cmd.walk_init;
        end
    end

    assign sts.cnt_zero  = (cnt_reg == '0);
    assign sts.room      = (loaded_reg < NW'(MAX_ITEMS));
    assign sts.walk_done = (walk_n_reg == '0) || (walk_w_reg == '0);
    assign sts.sel_none  = !(any_reg && next_any);

    assign result_valid = cmd.emit_fire;
    assign total_value  = total_reg;
    assign has_item     = any_reg;
    assign item_index   = any_reg ? ks_pkg::IDX_W'(cur_reg) : '0;
    assign sel_weight   = any_reg ? sw_q : '0;
    assign sel_value    = any_reg ? sv_q : '0;
    assign last_result  = !(any_reg && next_any);
endmodule

>>> rtl/knapsack_01_dp_select_unit.sv
// knapsack_01_dp_select_unit: top level, APB register, controller and datapath.
// Depends on ks_pkg, ks_ctrl, ks_dp, ks_ram.
//
//  channel   | ports                                         | transfer when
//  ----------+-----------------------------------------------+---------------------------
//  item in   | start, item_weight, item_value, last_item     | start && !busy
//  result    | result_valid, total_value, has_item, ...      | result_valid (one cycle)
//  config    | psel, penable, pwrite, paddr, pwdata, prdata  | psel && penable && pwrite
//
// First item of a set: clear pass over MAX_CAPACITY+1 cells of the best row.
// Each item: a row pass over cells C down to 0, C the latched capacity; each cell is
// read in ST_RD and written back in ST_UPD, and busy holds until the pass ends.
// Last item: ST_DONE, ST_WALK_RD/ST_WALK per item walked, ST_EMIT_RD/ST_EMIT per result.
// Reset clears control state; RAM contents are undefined until written.
// The receiver cannot stall: results go out one per strobe.
module knapsack_01_dp_select_unit #(
    parameter int MAX_ITEMS    = ks_pkg::MAX_ITEMS_DEF,
    parameter int MAX_CAPACITY = ks_pkg::MAX_CAPACITY_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [1:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     start,
    output logic                     busy,
    input  logic [ks_pkg::WT_W-1:0]  item_weight,
    input  logic [ks_pkg::IV_W-1:0]  item_value,
    input  logic                     last_item,
    output logic                     result_valid,
    output logic [ks_pkg::VAL_W-1:0] total_value,
    output logic                     has_item,
    output logic [ks_pkg::IDX_W-1:0] item_index,
    output logic [ks_pkg::WT_W-1:0]  sel_weight,
    output logic [ks_pkg::IV_W-1:0]  sel_value,
    output logic                     last_result
);
    logic [ks_pkg::WT_W-1:0] capacity_reg;
    ks_pkg::ks_cmd_t cmd;
    ks_pkg::ks_sts_t sts;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite &&
                    (paddr == {ks_pkg::REG_CAPACITY});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= 8'd255;
        end
        else if (wr_en)
        begin
            capacity_reg <= pwdata[ks_pkg::WT_W-1:0];
        end
    end

    assign prdata = (paddr == {ks_pkg::REG_CAPACITY}) ? {24'd0, capacity_reg} : '0;

    ks_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .last_item(last_item),
        .sts(sts), .cmd(cmd), .busy(busy)
    );

    ks_dp #(.MAX_ITEMS(MAX_ITEMS), .MAX_CAPACITY(MAX_CAPACITY)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .capacity(capacity_reg), .item_weight(item_weight), .item_value(item_value),
        .result_valid(result_valid), .total_value(total_value), .has_item(has_item),
        .item_index(item_index), .sel_weight(sel_weight), .sel_value(sel_value),
        .last_result(last_result)
    );

    // results only while busy
    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy) else $error("result while idle");
    // a final result frees the block next cycle
    a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_result) |=> !busy) else $error("busy after last result");
    // an empty result is always the last one
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !has_item) |-> last_result) else $error("empty not last");
endmodule
